[sv/lpw_pkg.sv]
// Package with the coordinate widths, item types, codes and helpers of the line pixel walker.
`timescale 1ns / 1ps
`default_nettype none

package lpw_pkg;

    localparam int COORD_BITS = 8;
    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic signed [SPAN_BITS-1:0] t_span;
    typedef logic [PROD_BITS-1:0]        t_prod;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
    } t_in_item;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       last_pixel;
    } t_out_item;

    typedef struct packed {
        t_coord position_x;
        t_coord position_y;
        t_coord target_x;
        t_coord target_y;
        t_span  span_x;
        t_span  span_y;
        logic   line_active;
    } t_walk_state;

    function automatic t_span coord_diff(input t_coord a, input t_coord b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic t_coord span_mag(input t_span v);
        t_span m;
        m = v[SPAN_BITS-1] ? -v : v;
        return m[COORD_BITS-1:0];
    endfunction

    function automatic t_coord step_toward(input t_coord p, input t_span dir);
        t_coord r;
        if (dir[SPAN_BITS-1]) begin
            r = p - t_coord'(1);
        end else if (dir != '0) begin
            r = p + t_coord'(1);
        end else begin
            r = p;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/line_pixel_walker_core.sv]
// Top level of the line pixel walker: input register, walk state and result register.
`timescale 1ns / 1ps
`default_nettype none

// A load transaction sets the start and end points and gives no result; each step transaction
// gives one result with the current pixel, or pixel_valid 0 when no line is active, and moves
// the walk one unit in x or y along a 4-connected path. The end pixel is never given. One
// transaction is taken per clock cycle while the input is not stalled; each passes the input
// register, and a step's result then passes the result register, which holds it on the output
// until it is taken. The only throttle is a stalled output
// while the result register is full and a step transaction waits in the input register.

module line_pixel_walker_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire lpw_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output lpw_pkg::t_out_item      o_out_item
);

    logic                 r_in_valid;
    lpw_pkg::t_in_item    r_in_item;
    lpw_pkg::t_walk_state r_state;
    lpw_pkg::t_walk_state n_state;
    lpw_pkg::t_out_item   n_result;
    logic                 out_free;
    logic                 advance;
    logic                 take_in;

    assign advance = r_in_valid &&
                     ((r_in_item.operation == lpw_pkg::OP_LOAD) || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    lpw_step_logic u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    lpw_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && (r_in_item.operation == lpw_pkg::OP_STEP)),
        .i_item  (n_result),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (take_in || advance) begin
                r_in_valid <= take_in;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_item <= i_in_item;
        end
    end

endmodule

`default_nettype wire

[sv/lpw_step_logic.sv]
// Combinational step of the walker: next state and result for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module lpw_step_logic (
    input  wire lpw_pkg::t_walk_state i_state,
    input  wire lpw_pkg::t_in_item    i_item,
    output lpw_pkg::t_walk_state      o_state,
    output lpw_pkg::t_out_item        o_result
);

    lpw_pkg::t_coord xs;
    lpw_pkg::t_coord ys;
    lpw_pkg::t_coord xe;
    lpw_pkg::t_coord ye;
    lpw_pkg::t_prod  lhs;
    lpw_pkg::t_prod  rhs;
    lpw_pkg::t_coord nx;
    lpw_pkg::t_coord ny;
    logic            move_x;
    logic            idle;
    logic            last;

    always_comb begin
        xs = lpw_pkg::t_coord'(i_item.x_start);
        ys = lpw_pkg::t_coord'(i_item.y_start);
        xe = lpw_pkg::t_coord'(i_item.x_end);
        ye = lpw_pkg::t_coord'(i_item.y_end);

        lhs = lpw_pkg::t_prod'(lpw_pkg::span_mag(
                  lpw_pkg::coord_diff(i_state.target_x, i_state.position_x)))
            * lpw_pkg::t_prod'(lpw_pkg::span_mag(i_state.span_y));
        rhs = lpw_pkg::t_prod'(lpw_pkg::span_mag(
                  lpw_pkg::coord_diff(i_state.target_y, i_state.position_y)))
            * lpw_pkg::t_prod'(lpw_pkg::span_mag(i_state.span_x));
        move_x = (i_state.span_x != '0) && (lhs >= rhs);

        nx = move_x ? lpw_pkg::step_toward(i_state.position_x, i_state.span_x)
                    : i_state.position_x;
        ny = move_x ? i_state.position_y
                    : lpw_pkg::step_toward(i_state.position_y, i_state.span_y);
        last = (nx == i_state.target_x) && (ny == i_state.target_y);

        idle = !i_state.line_active ||
               ((i_state.position_x == i_state.target_x) &&
                (i_state.position_y == i_state.target_y));

        o_state  = i_state;
        o_result = '0;
        if (i_item.operation == lpw_pkg::OP_LOAD) begin
            o_state.position_x  = xs;
            o_state.position_y  = ys;
            o_state.target_x    = xe;
            o_state.target_y    = ye;
            o_state.span_x      = lpw_pkg::coord_diff(xe, xs);
            o_state.span_y      = lpw_pkg::coord_diff(ye, ys);
            o_state.line_active = (xs != xe) || (ys != ye);
        end else if (idle) begin
            o_state.line_active = 1'b0;
        end else begin
            o_state.position_x   = nx;
            o_state.position_y   = ny;
            o_state.line_active  = !last;
            o_result.pixel_valid = 1'b1;
            o_result.pixel_x     = 8'(i_state.position_x);
            o_result.pixel_y     = 8'(i_state.position_y);
            o_result.last_pixel  = last;
        end
    end

endmodule

`default_nettype wire

[sv/lpw_out_reg.sv]
// Result register that holds one result transaction while the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module lpw_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire lpw_pkg::t_out_item i_item,
    input  wire                     i_stall,
    output logic                    o_free,
    output logic                    o_valid,
    output lpw_pkg::t_out_item      o_item
);

    logic               r_valid;
    logic               n_valid;
    lpw_pkg::t_out_item r_item;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[sv/lpw_checker.sv]
// Port checker for the line pixel walker and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lpw_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_in_stall,
    input wire                     o_out_valid,
    input wire                     i_out_stall,
    input wire lpw_pkg::t_out_item o_out_item
);

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled result transaction changed.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.pixel_valid |->
            o_out_item.pixel_x == 8'd0 && o_out_item.pixel_y == 8'd0 &&
            !o_out_item.last_pixel)
        else $error("Empty result carries nonzero fields.");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_pixel |-> o_out_item.pixel_valid)
        else $error("Last pixel flag without a pixel.");

    a_in_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("Input stalled although the result register was empty.");

endmodule

bind line_pixel_walker_core lpw_checker u_lpw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

[tb/line_pixel_walker_core_test.sv]
// Self-checking testbench that walks random and corner-case lines through line_pixel_walker_core.
`timescale 1ns / 1ps

module line_pixel_walker_core_test;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    lpw_pkg::t_in_item  in_item = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    lpw_pkg::t_out_item out_item;

    lpw_pkg::t_in_item  pending[$];
    lpw_pkg::t_out_item pixel_queue[$];

    lpw_pkg::t_coord walk_pos_x = '0;
    lpw_pkg::t_coord walk_pos_y = '0;
    lpw_pkg::t_coord walk_tgt_x = '0;
    lpw_pkg::t_coord walk_tgt_y = '0;
    lpw_pkg::t_span  walk_span_x = '0;
    lpw_pkg::t_span  walk_span_y = '0;
    logic            walk_active = 1'b0;

    int txn_count = 0;
    int total_items = 0;
    int drain_at = -1;
    bit drained = 1'b0;
    int phase = 0;
    int mismatches = 0;
    int cycle_count = 0;

    line_pixel_walker_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #2 clk = ~clk;

    function automatic int send_idle_pct(input int ph);
        case (ph)
            0: return 14;
            1: return 87;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int ph);
        case (ph)
            0: return 87;
            1: return 14;
            default: return 0;
        endcase
    endfunction

    function automatic int sign_of(input int v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Updates the walk state for one accepted transaction and, for a step, queues the result it should give.
    task automatic advance_walk(input lpw_pkg::t_in_item item);
        lpw_pkg::t_out_item pix;
        int                 dx;
        int                 dy;
        logic               move_x;
        pix = '0;
        if (item.operation == lpw_pkg::OP_LOAD) begin
            walk_pos_x  = item.x_start;
            walk_pos_y  = item.y_start;
            walk_tgt_x  = item.x_end;
            walk_tgt_y  = item.y_end;
            walk_span_x = lpw_pkg::t_span'(int'(item.x_end) - int'(item.x_start));
            walk_span_y = lpw_pkg::t_span'(int'(item.y_end) - int'(item.y_start));
            walk_active = (item.x_start != item.x_end) || (item.y_start != item.y_end);
        end else if (!walk_active || (walk_pos_x == walk_tgt_x && walk_pos_y == walk_tgt_y)) begin
            walk_active = 1'b0;
            pixel_queue.push_back(pix);
        end else begin
            pix.pixel_valid = 1'b1;
            pix.pixel_x = walk_pos_x;
            pix.pixel_y = walk_pos_y;
            dx = int'(walk_tgt_x) - int'(walk_pos_x);
            dy = int'(walk_tgt_y) - int'(walk_pos_y);
            if (walk_span_x == 0) begin
                move_x = 1'b0;
            end else begin
                move_x = magnitude(dx) * magnitude(int'(walk_span_y))
                         >= magnitude(dy) * magnitude(int'(walk_span_x));
            end
            if (move_x) begin
                walk_pos_x = lpw_pkg::t_coord'(int'(walk_pos_x) + sign_of(int'(walk_span_x)));
            end else begin
                walk_pos_y = lpw_pkg::t_coord'(int'(walk_pos_y) + sign_of(int'(walk_span_y)));
            end
            pix.last_pixel = (walk_pos_x == walk_tgt_x) && (walk_pos_y == walk_tgt_y);
            if (pix.last_pixel) begin
                walk_active = 1'b0;
            end
            pixel_queue.push_back(pix);
        end
    endtask

    task automatic add_load(input int xs, input int ys, input int xe, input int ye);
        lpw_pkg::t_in_item item;
        item.operation = lpw_pkg::OP_LOAD;
        item.x_start = 8'(xs);
        item.y_start = 8'(ys);
        item.x_end = 8'(xe);
        item.y_end = 8'(ye);
        pending.push_back(item);
    endtask

    task automatic add_steps(input int n);
        lpw_pkg::t_in_item item;
        for (int i = 0; i < n; i++) begin
            item.operation = lpw_pkg::OP_STEP;
            item.x_start = 8'($urandom);
            item.y_start = 8'($urandom);
            item.x_end = 8'($urandom);
            item.y_end = 8'($urandom);
            pending.push_back(item);
        end
    endtask

    function automatic int pick_end(input int c, input int reach);
        int d;
        int e;
        d = int'($urandom_range(0, 2 * reach)) - reach;
        e = c + d;
        if (e < 0 || e > 255) begin
            e = c - d;
        end
        return e;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                advance_walk(in_item);
                txn_count++;
            end
            if (!drained && txn_count == drain_at && pixel_queue.size() == 0) begin
                drained = 1'b1;
            end
            if (!in_valid || !in_stall) begin
                if (pending.size() != 0 && (drained || txn_count != drain_at)
                        && $urandom_range(0, 99) >= send_idle_pct(phase)) begin
                    in_item <= pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            phase <= (txn_count < total_items / 3) ? 0 :
                     (txn_count < 2 * total_items / 3) ? 1 : 2;
        end
    end

    always @(posedge clk) begin
        lpw_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected result transaction: pixel_x %0d, pixel_y %0d",
                           out_item.pixel_x, out_item.pixel_y);
                    mismatches++;
                end else begin
                    want = pixel_queue.pop_front();
                    check_field("pixel_valid", want.pixel_valid, out_item.pixel_valid);
                    check_field("pixel_x", want.pixel_x, out_item.pixel_x);
                    check_field("pixel_y", want.pixel_y, out_item.pixel_y);
                    check_field("last_pixel", want.last_pixel, out_item.last_pixel);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct(phase));
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int first_random;
        int pick;
        int reach;
        int xs;
        int ys;
        int xe;
        int ye;
        int len;
        int n;

        // Step with no line loaded, then an empty line.
        add_steps(1);
        add_load(7, 7, 7, 7);
        add_steps(1);
        // Horizontal lines both ways, one of them at the edge of the coordinate range.
        add_load(3, 5, 6, 5);
        add_steps(3);
        add_load(255, 0, 253, 0);
        add_steps(3);
        // Vertical lines going up and going down.
        add_load(0, 2, 0, 0);
        add_steps(2);
        add_load(255, 253, 255, 255);
        add_steps(3);
        // Full-range diagonal abandoned early, then a short sloped line.
        add_load(255, 255, 0, 0);
        add_steps(3);
        add_load(0, 0, 2, 1);
        add_steps(3);

        first_random = pending.size();
        while (pending.size() < first_random + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                reach = (pick < 70) ? 10 : 60;
                xs = $urandom_range(0, 255);
                ys = $urandom_range(0, 255);
                xe = pick_end(xs, reach);
                ye = pick_end(ys, reach);
                len = magnitude(xe - xs) + magnitude(ye - ys);
                n = len + $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, len);
                end
                add_load(xs, ys, xe, ye);
                add_steps(n);
            end else if (pick < 90) begin
                add_load($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
                add_steps($urandom_range(0, 4));
            end else if (pick < 95) begin
                xs = $urandom_range(0, 255);
                ys = $urandom_range(0, 255);
                add_load(xs, ys, xs, ys);
                add_steps($urandom_range(0, 2));
            end else begin
                add_steps($urandom_range(1, 3));
            end
        end
        total_items = pending.size();
        drain_at = total_items / 2;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (txn_count < total_items) @(posedge clk);
        while (pixel_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
